// ===== src/ucra_pkg.sv =====
// Shared types and constants for the usage-counted register allocator.
// No dependencies; every other file of the block but ucra_ram refers to this package.
package ucra_pkg;

	// Field widths of the item channels
	typedef logic [2:0] opcode_t;
	typedef logic [1:0] comp_t;
	typedef logic [4:0] idx_t;
	typedef logic [7:0] count_t;
	typedef logic [1:0] status_t;
	typedef logic [5:0] active_t;

	// Opcodes
	localparam opcode_t OP_CLEAR    = 3'd0;
	localparam opcode_t OP_REQ_VEC  = 3'd1;
	localparam opcode_t OP_REQ_COMP = 3'd2;
	localparam opcode_t OP_ADD      = 3'd3;
	localparam opcode_t OP_REMOVE   = 3'd4;
	localparam opcode_t OP_QUERY    = 3'd5;

	// Result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	// Components per register and count limits
	localparam int     COMPS     = 4;
	localparam count_t CNT_MAX   = 8'hFF;
	localparam count_t CNT_ONE   = 8'h01;
	localparam count_t CNT_ZERO  = 8'h00;

	// Configuration register indexes (selected by paddr[2])
	localparam logic REG_ACTIVE  = 1'b0;
	localparam logic REG_PERSIST = 1'b1;

	// Reset values of the configuration registers
	localparam active_t ACTIVE_RST  = 6'd32;
	localparam logic    PERSIST_RST = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic take;    // ready for a new item
		logic commit;  // apply the latched item and load the result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_valid;  // an item is offered
		logic out_free;  // the result register can be loaded this cycle
	} stat_t;

endpackage

// ===== src/ucra_if.sv =====
// Item channel interfaces (valid/ready handshake plus payload).
// Depends on ucra_pkg for the field types.
interface ucra_in_if;
	logic                 valid;
	logic                 ready;
	ucra_pkg::opcode_t    opcode;
	logic                 is_vector;
	ucra_pkg::comp_t      component_sel;
	ucra_pkg::idx_t       reg_index;
	ucra_pkg::count_t     usage_amount;

	modport source (output valid, output opcode, output is_vector, output component_sel,
		output reg_index, output usage_amount, input ready);
	modport sink (input valid, input opcode, input is_vector, input component_sel,
		input reg_index, input usage_amount, output ready);
endinterface

interface ucra_out_if;
	logic                 valid;
	logic                 ready;
	ucra_pkg::status_t    status;
	ucra_pkg::idx_t       granted_index;
	ucra_pkg::comp_t      granted_component;
	logic                 any_in_use;

	modport source (output valid, output status, output granted_index,
		output granted_component, output any_in_use, input ready);
	modport sink (input valid, input status, input granted_index,
		input granted_component, input any_in_use, output ready);
endinterface

// ===== src/ucra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ucra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 160,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/ucra_ctrl.sv =====
// Controller state machine: accept an item, then commit it once the result
// register is free. Depends on ucra_pkg for the command and status structs.
module ucra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  ucra_pkg::stat_t stat,
	output ucra_pkg::cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands
	assign cmd.take   = (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_EXEC) && stat.out_free;

endmodule

// ===== src/ucra_datapath.sv =====
// Datapath: nonzero flags, count memory, first-free search and result register.
// Depends on ucra_pkg, ucra_if and ucra_ram.
module ucra_datapath #(
	parameter int REGS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	ucra_in_if.sink           in_ch,
	ucra_out_if.source        out_ch,
	input  ucra_pkg::active_t active_registers,
	input  logic              persistent_mode,
	input  ucra_pkg::cmd_t    cmd,
	output ucra_pkg::stat_t   stat
);

	localparam int IW    = (REGS > 1) ? $clog2(REGS) : 1;
	localparam int NC    = REGS * ucra_pkg::COMPS;
	localparam int CW    = $clog2(NC);
	localparam int DEPTH = REGS + NC;
	localparam int AW    = $clog2(DEPTH);

	// Nonzero flags: a clear flag means the count reads as zero
	logic [REGS-1:0] vec_nz_q;
	logic [NC-1:0]   comp_nz_q;

	// Latched item
	ucra_pkg::opcode_t op_q;
	logic              vec_q;
	ucra_pkg::count_t  amt_q;
	logic [IW-1:0]     ridx_q;
	logic [CW-1:0]     cidx_q;
	logic [AW-1:0]     addr_q;
	logic              in_range_q;
	logic              flag_q;

	// Accept side
	logic              accept;
	logic [IW-1:0]     ridx_in;
	logic [CW-1:0]     cidx_in;
	logic [AW-1:0]     rd_addr_in;
	logic              in_range_in;
	logic              flag_in;
	ucra_pkg::count_t  ram_rd;

	assign accept      = in_ch.valid && in_ch.ready;
	assign ridx_in     = IW'(32'(in_ch.reg_index));
	assign cidx_in     = CW'((32'(in_ch.reg_index) << 2) | 32'(in_ch.component_sel));
	assign in_range_in = 32'(in_ch.reg_index) < 32'(REGS);
	assign flag_in     = in_ch.is_vector ? vec_nz_q[ridx_in] : comp_nz_q[cidx_in];
	assign rd_addr_in  = in_ch.is_vector ? AW'(32'(ridx_in)) : AW'(32'(REGS) + 32'(cidx_in));

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_ch.opcode;
			vec_q      <= in_ch.is_vector;
			amt_q      <= in_ch.usage_amount;
			ridx_q     <= ridx_in;
			cidx_q     <= cidx_in;
			addr_q     <= rd_addr_in;
			in_range_q <= in_range_in;
			flag_q     <= flag_in && in_range_in;
		end
	end

	// Search masks over the active part of the pool
	logic [REGS-1:0] mask;
	logic [REGS-1:0] free_vec;
	logic [NC-1:0]   free_comp;
	logic            any_busy;

	always_comb begin
		for (int r = 0; r < REGS; r++) begin
			mask[r]     = 32'(r) < 32'(active_registers);
			free_vec[r] = mask[r] && !vec_nz_q[r] && !(|comp_nz_q[r*ucra_pkg::COMPS +: 4]);
			for (int c = 0; c < ucra_pkg::COMPS; c++) begin
				free_comp[r*ucra_pkg::COMPS + c] = mask[r] && !vec_nz_q[r] &&
					!comp_nz_q[r*ucra_pkg::COMPS + c];
			end
		end
		any_busy = |(mask & ~free_vec);
	end

	// Lowest free register and lowest free component
	logic          vec_hit;
	logic [IW-1:0] vec_idx;
	logic          comp_hit;
	logic [CW-1:0] comp_idx;

	always_comb begin
		vec_hit = 1'b0;
		vec_idx = '0;
		for (int i = REGS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				vec_hit = 1'b1;
				vec_idx = IW'(i);
			end
		end
	end

	always_comb begin
		comp_hit = 1'b0;
		comp_idx = '0;
		for (int i = NC - 1; i >= 0; i--) begin
			if (free_comp[i]) begin
				comp_hit = 1'b1;
				comp_idx = CW'(i);
			end
		end
	end

	// Count arithmetic for add and remove
	ucra_pkg::count_t cnt;
	logic [8:0]       sum9;
	ucra_pkg::count_t add_val;
	ucra_pkg::count_t sub_val;

	assign cnt     = flag_q ? ram_rd : ucra_pkg::CNT_ZERO;
	assign sum9    = {1'b0, cnt} + {1'b0, amt_q};
	assign add_val = sum9[8] ? ucra_pkg::CNT_MAX : sum9[7:0];
	assign sub_val = cnt - ucra_pkg::CNT_ONE;

	// Result and update selection
	ucra_pkg::status_t res_status;
	ucra_pkg::idx_t    res_idx;
	ucra_pkg::comp_t   res_comp;
	logic              res_any;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	ucra_pkg::count_t  wr_data;
	logic              clear_all;
	logic              vec_set_en;
	logic [IW-1:0]     vec_set_idx;
	logic              comp_set_en;
	logic [CW-1:0]     comp_set_idx;
	logic              set_val;

	always_comb begin
		res_status   = ucra_pkg::ST_OK;
		res_idx      = '0;
		res_comp     = '0;
		res_any      = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = addr_q;
		wr_data      = ucra_pkg::CNT_ZERO;
		clear_all    = 1'b0;
		vec_set_en   = 1'b0;
		vec_set_idx  = ridx_q;
		comp_set_en  = 1'b0;
		comp_set_idx = cidx_q;
		set_val      = 1'b1;
		case (op_q)
			ucra_pkg::OP_CLEAR: begin
				clear_all = 1'b1;
			end
			ucra_pkg::OP_REQ_VEC: begin
				if (vec_hit) begin
					res_idx = ucra_pkg::idx_t'(32'(vec_idx));
					if (persistent_mode) begin
						vec_set_en  = 1'b1;
						vec_set_idx = vec_idx;
						wr_en       = 1'b1;
						wr_addr     = AW'(32'(vec_idx));
						wr_data     = ucra_pkg::CNT_ONE;
					end
				end else begin
					res_status = ucra_pkg::ST_OVERFLOW;
				end
			end
			ucra_pkg::OP_REQ_COMP: begin
				if (comp_hit) begin
					res_idx  = ucra_pkg::idx_t'(32'(comp_idx) >> 2);
					res_comp = ucra_pkg::comp_t'(comp_idx[1:0]);
					if (persistent_mode) begin
						comp_set_en  = 1'b1;
						comp_set_idx = comp_idx;
						wr_en        = 1'b1;
						wr_addr      = AW'(32'(REGS) + 32'(comp_idx));
						wr_data      = ucra_pkg::CNT_ONE;
					end
				end else begin
					res_status = ucra_pkg::ST_OVERFLOW;
				end
			end
			ucra_pkg::OP_ADD: begin
				if (in_range_q) begin
					wr_en       = 1'b1;
					wr_data     = add_val;
					set_val     = add_val != ucra_pkg::CNT_ZERO;
					vec_set_en  = vec_q;
					comp_set_en = !vec_q;
				end
			end
			ucra_pkg::OP_REMOVE: begin
				if (in_range_q) begin
					if (cnt == ucra_pkg::CNT_ZERO) begin
						res_status = ucra_pkg::ST_UNDERFLOW;
					end else begin
						wr_en       = 1'b1;
						wr_data     = sub_val;
						set_val     = sub_val != ucra_pkg::CNT_ZERO;
						vec_set_en  = vec_q;
						comp_set_en = !vec_q;
					end
				end
			end
			ucra_pkg::OP_QUERY: begin
				res_any = any_busy;
			end
			default: begin
			end
		endcase
	end

	// Flag update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_nz_q  <= '0;
			comp_nz_q <= '0;
		end else if (cmd.commit) begin
			if (clear_all) begin
				vec_nz_q  <= '0;
				comp_nz_q <= '0;
			end else begin
				if (vec_set_en) begin
					vec_nz_q[vec_set_idx] <= set_val;
				end
				if (comp_set_en) begin
					comp_nz_q[comp_set_idx] <= set_val;
				end
			end
		end
	end

	// Count memory: vector counts first, then component counts
	ucra_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (wr_en && cmd.commit),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr_in),
		.rd_data (ram_rd)
	);

	// Result register
	logic              out_valid_q;
	ucra_pkg::status_t status_q;
	ucra_pkg::idx_t    gidx_q;
	ucra_pkg::comp_t   gcomp_q;
	logic              any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_status;
			gidx_q   <= res_idx;
			gcomp_q  <= res_comp;
			any_q    <= res_any;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.status            = status_q;
	assign out_ch.granted_index     = gidx_q;
	assign out_ch.granted_component = gcomp_q;
	assign out_ch.any_in_use        = any_q;

	// Handshake and controller status
	assign in_ch.ready   = cmd.take;
	assign stat.in_valid = in_ch.valid;
	assign stat.out_free = !out_valid_q || out_ch.ready;

endmodule

// ===== src/usage_counted_register_allocator.sv =====
// Usage-counted register allocator: top level with the APB register port.
// Depends on ucra_pkg, ucra_if, ucra_ctrl and ucra_datapath.
//
// Each item is handled in an accept step, in which the count memory is read at
// the addressed entry, and an execute step, in which the nonzero flags of the
// pool are searched by a priority encoder, at most one count is written back
// and the result register is loaded. The next item is taken in the cycle after
// the load, while the result may still wait at the output; execute
// holds only while an earlier result is still not taken. Counts live in a
// memory of REGS*5 entries; a flop per entry marks it nonzero, so clear and
// reset take effect at once with no clearing pass. Registers: active_registers
// at byte address 0, persistent_mode at 4.
module usage_counted_register_allocator #(
	parameter int REGS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ucra_in_if.sink     in_ch,
	ucra_out_if.source  out_ch
);

	ucra_pkg::active_t active_q;
	logic              persist_q;
	logic              cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ucra_pkg::ACTIVE_RST;
			persist_q <= ucra_pkg::PERSIST_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ucra_pkg::REG_ACTIVE) begin
				active_q <= pwdata[5:0];
			end else begin
				persist_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == ucra_pkg::REG_PERSIST) ? {31'd0, persist_q} :
		{26'd0, active_q};

	ucra_pkg::cmd_t  cmd;
	ucra_pkg::stat_t stat;

	ucra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	ucra_datapath #(
		.REGS (REGS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.out_ch           (out_ch),
		.active_registers (active_q),
		.persistent_mode  (persist_q),
		.cmd              (cmd),
		.stat             (stat)
	);

endmodule

// ===== test/usage_counted_register_allocator_tb.sv =====
// Testbench for the usage-counted register allocator: directed and random items,
// checked against a predictor of the count pool. Depends on ucra_pkg, ucra_if and
// the usage_counted_register_allocator top level.
module usage_counted_register_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_REGS = 32;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 40;

	// opcodes the block leaves unused
	localparam ucra_pkg::opcode_t OP_RSVD6 = 3'd6;
	localparam ucra_pkg::opcode_t OP_RSVD7 = 3'd7;

	typedef struct packed {
		ucra_pkg::opcode_t op;
		logic              vec;
		ucra_pkg::comp_t   comp;
		ucra_pkg::idx_t    idx;
		ucra_pkg::count_t  amt;
	} alloc_req_t;

	typedef struct packed {
		ucra_pkg::status_t st;
		ucra_pkg::idx_t    gidx;
		ucra_pkg::comp_t   gcomp;
		logic              inuse;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ucra_in_if  req_ch ();
	ucra_out_if rsp_ch ();

	usage_counted_register_allocator #(.REGS(POOL_REGS)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (req_ch),
		.out_ch  (rsp_ch)
	);

	// predicted pool state and configuration
	ucra_pkg::count_t  vec_use [POOL_REGS];
	ucra_pkg::count_t  comp_use [POOL_REGS][ucra_pkg::COMPS];
	ucra_pkg::active_t cfg_active = ucra_pkg::ACTIVE_RST;
	logic              cfg_persist = ucra_pkg::PERSIST_RST;

	grant_t  grant_expect_q [$];

	int      src_idle_pct = 0;
	int      snk_stall_pct = 0;
	logic    hold_on = 1'b0;
	event    hold_ev;

	int      err_cnt = 0;
	int      n_items = 0;
	int      n_checked = 0;
	int      n_overflow = 0;
	int      n_underflow = 0;
	int      n_busy_query = 0;
	int      n_settings = 0;

	always #6 clk = ~clk;

	// one line per mismatch up to MAX_REPORTS, every mismatch counted
	task automatic note_mismatch(input string what, input int got, input int want);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	function automatic logic reg_in_use(input int r);
		if (vec_use[r] != ucra_pkg::CNT_ZERO)
			return 1'b1;
		for (int c = 0; c < ucra_pkg::COMPS; c++)
			if (comp_use[r][c] != ucra_pkg::CNT_ZERO)
				return 1'b1;
		return 1'b0;
	endfunction

	// apply one item to the predicted pool and return its result
	function automatic grant_t apply_to_pool(input alloc_req_t q);
		grant_t           g;
		int               lim;
		logic             hit;
		ucra_pkg::count_t cnt;
		logic [8:0]       sum;
		g = '0;
		hit = 1'b0;
		lim = (int'(cfg_active) < POOL_REGS) ? int'(cfg_active) : POOL_REGS;
		case (q.op)
			ucra_pkg::OP_CLEAR: begin
				foreach (vec_use[r])
					vec_use[r] = ucra_pkg::CNT_ZERO;
				foreach (comp_use[r, c])
					comp_use[r][c] = ucra_pkg::CNT_ZERO;
			end
			ucra_pkg::OP_REQ_VEC: begin
				for (int r = 0; r < lim && !hit; r++) begin
					if (!reg_in_use(r)) begin
						hit = 1'b1;
						g.gidx = ucra_pkg::idx_t'(r);
						if (cfg_persist)
							vec_use[r] = ucra_pkg::CNT_ONE;
					end
				end
				if (!hit)
					g.st = ucra_pkg::ST_OVERFLOW;
			end
			ucra_pkg::OP_REQ_COMP: begin
				// registers held as whole vectors are skipped
				for (int r = 0; r < lim && !hit; r++) begin
					if (vec_use[r] == ucra_pkg::CNT_ZERO) begin
						for (int c = 0; c < ucra_pkg::COMPS && !hit; c++) begin
							if (comp_use[r][c] == ucra_pkg::CNT_ZERO) begin
								hit = 1'b1;
								g.gidx = ucra_pkg::idx_t'(r);
								g.gcomp = ucra_pkg::comp_t'(c);
								if (cfg_persist)
									comp_use[r][c] = ucra_pkg::CNT_ONE;
							end
						end
					end
				end
				if (!hit)
					g.st = ucra_pkg::ST_OVERFLOW;
			end
			ucra_pkg::OP_ADD, ucra_pkg::OP_REMOVE: begin
				cnt = q.vec ? vec_use[q.idx] : comp_use[q.idx][q.comp];
				if (q.op == ucra_pkg::OP_ADD) begin
					sum = {1'b0, cnt} + {1'b0, q.amt};
					cnt = sum[8] ? ucra_pkg::CNT_MAX : sum[7:0];
				end else if (cnt == ucra_pkg::CNT_ZERO) begin
					g.st = ucra_pkg::ST_UNDERFLOW;
				end else begin
					cnt = cnt - ucra_pkg::CNT_ONE;
				end
				if (q.vec)
					vec_use[q.idx] = cnt;
				else
					comp_use[q.idx][q.comp] = cnt;
			end
			ucra_pkg::OP_QUERY: begin
				for (int r = 0; r < lim; r++)
					if (reg_in_use(r))
						g.inuse = 1'b1;
			end
			default: ;
		endcase
		return g;
	endfunction

	function automatic alloc_req_t mk_req(input ucra_pkg::opcode_t op, input logic vec,
		input ucra_pkg::comp_t comp, input ucra_pkg::idx_t idx, input ucra_pkg::count_t amt);
		alloc_req_t q;
		q.op = op;
		q.vec = vec;
		q.comp = comp;
		q.idx = idx;
		q.amt = amt;
		return q;
	endfunction

	// random item: requests dominate, add/remove mostly hit the searched registers
	function automatic alloc_req_t random_req();
		alloc_req_t q;
		int         pick;
		int         lim;
		q.vec = 1'($urandom_range(1));
		q.comp = ucra_pkg::comp_t'($urandom_range(3));
		q.idx = ucra_pkg::idx_t'($urandom_range(POOL_REGS - 1));
		lim = (int'(cfg_active) < POOL_REGS) ? int'(cfg_active) : POOL_REGS;
		if (lim > 0 && $urandom_range(9) < 7)
			q.idx = ucra_pkg::idx_t'($urandom_range(lim - 1));
		case ($urandom_range(2))
			0: q.amt = ucra_pkg::count_t'($urandom_range(3, 1));
			1: q.amt = ucra_pkg::count_t'($urandom_range(255, 200));
			default: q.amt = ucra_pkg::count_t'($urandom_range(255));
		endcase
		pick = $urandom_range(99);
		if (pick < 3)
			q.op = ucra_pkg::OP_CLEAR;
		else if (pick < 28)
			q.op = ucra_pkg::OP_REQ_VEC;
		else if (pick < 53)
			q.op = ucra_pkg::OP_REQ_COMP;
		else if (pick < 68)
			q.op = ucra_pkg::OP_ADD;
		else if (pick < 85)
			q.op = ucra_pkg::OP_REMOVE;
		else if (pick < 95)
			q.op = ucra_pkg::OP_QUERY;
		else
			q.op = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
		return q;
	endfunction

	// offer one item; returns at the edge that accepts it, valid left high
	task automatic offer_op(input alloc_req_t q);
		grant_t g;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= q.op;
		req_ch.is_vector <= q.vec;
		req_ch.component_sel <= q.comp;
		req_ch.reg_index <= q.idx;
		req_ch.usage_amount <= q.amt;
		do
			@(posedge clk);
		while (!req_ch.ready);
		g = apply_to_pool(q);
		grant_expect_q = {grant_expect_q, g};
		n_items++;
		if (g.st == ucra_pkg::ST_OVERFLOW)
			n_overflow++;
		if (g.st == ucra_pkg::ST_UNDERFLOW)
			n_underflow++;
		if (g.inuse)
			n_busy_query++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (grant_expect_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// APB write then read back; only called with the block idle
	task automatic set_alloc_reg(input logic sel, input logic [31:0] val);
		logic [31:0] mask;
		logic [31:0] rd;
		mask = (sel == ucra_pkg::REG_PERSIST) ? 32'h1 : 32'h3F;
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (sel == ucra_pkg::REG_PERSIST)
			cfg_persist = val[0];
		else
			cfg_active = ucra_pkg::active_t'(val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if ((rd & mask) != (val & mask))
			note_mismatch(sel == ucra_pkg::REG_PERSIST ? "persistent_mode readback"
				: "active_registers readback", int'(rd & mask), int'(val & mask));
	endtask

	task automatic apply_setting(input int active, input logic persist);
		set_alloc_reg(ucra_pkg::REG_ACTIVE, 32'(active));
		set_alloc_reg(ucra_pkg::REG_PERSIST, 32'(persist));
		n_settings++;
	endtask

	// claims, skipping, saturation, underflow, unused opcodes and clear
	task automatic test_directed_ops();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		offer_op(mk_req(ucra_pkg::OP_QUERY, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_VEC, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_COMP, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_COMP, 1'b1, 2'd3, 5'd31, 8'd255));
		offer_op(mk_req(ucra_pkg::OP_ADD, 1'b1, 2'd0, 5'd31, 8'd255));
		offer_op(mk_req(ucra_pkg::OP_ADD, 1'b1, 2'd0, 5'd31, 8'd1));
		offer_op(mk_req(ucra_pkg::OP_REMOVE, 1'b1, 2'd0, 5'd31, 8'd255));
		offer_op(mk_req(ucra_pkg::OP_REMOVE, 1'b0, 2'd3, 5'd5, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_ADD, 1'b0, 2'd3, 5'd2, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_QUERY, 1'b1, 2'd3, 5'd31, 8'd255));
		offer_op(mk_req(OP_RSVD6, 1'b1, 2'd3, 5'd31, 8'd255));
		offer_op(mk_req(OP_RSVD7, 1'b1, 2'd3, 5'd31, 8'd255));
		offer_op(mk_req(ucra_pkg::OP_CLEAR, 1'b1, 2'd3, 5'd31, 8'd255));
		offer_op(mk_req(ucra_pkg::OP_QUERY, 1'b0, 2'd0, 5'd0, 8'd0));
		// fill register 0 component by component, then search past it
		for (int c = 0; c < ucra_pkg::COMPS; c++)
			offer_op(mk_req(ucra_pkg::OP_ADD, 1'b0, ucra_pkg::comp_t'(c), 5'd0, 8'd1));
		offer_op(mk_req(ucra_pkg::OP_REQ_COMP, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REMOVE, 1'b0, 2'd2, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_COMP, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_VEC, 1'b0, 2'd0, 5'd0, 8'd0));
		drain();
	endtask

	// empty search range, then a single register without claiming
	task automatic test_search_bound();
		apply_setting(0, 1'b1);
		offer_op(mk_req(ucra_pkg::OP_REQ_VEC, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_COMP, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_QUERY, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_ADD, 1'b1, 2'd1, 5'd31, 8'd7));
		apply_setting(1, 1'b0);
		offer_op(mk_req(ucra_pkg::OP_REQ_VEC, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_REQ_COMP, 1'b0, 2'd0, 5'd0, 8'd0));
		offer_op(mk_req(ucra_pkg::OP_QUERY, 1'b0, 2'd0, 5'd0, 8'd0));
		drain();
	endtask

	task automatic test_random_phase(input int active, input logic persist, input int src_pct,
		input int snk_pct, input int count);
		apply_setting(active, persist);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (int i = 0; i < count; i++)
			offer_op(random_req());
		drain();
	endtask

	// receiver holds off while items keep coming, so the input stalls
	task automatic test_result_backpressure();
		apply_setting(8, 1'b1);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		-> hold_ev;
		for (int i = 0; i < 40; i++)
			offer_op(random_req());
		drain();
	endtask

	// long hold-off of the result side, counted here
	initial forever begin
		@(hold_ev);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// result-side ready
	always @(posedge clk) begin
		if (hold_on)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grant_expect_q.size() == 0) begin
				note_mismatch("unexpected result", 1, 0);
			end else begin
				want = grant_expect_q.pop_front();
				n_checked++;
				if (rsp_ch.status !== want.st)
					note_mismatch("status", int'(rsp_ch.status), int'(want.st));
				if (rsp_ch.granted_index !== want.gidx)
					note_mismatch("granted_index", int'(rsp_ch.granted_index),
						int'(want.gidx));
				if (rsp_ch.granted_component !== want.gcomp)
					note_mismatch("granted_component", int'(rsp_ch.granted_component),
						int'(want.gcomp));
				if (rsp_ch.any_in_use !== want.inuse)
					note_mismatch("any_in_use", int'(rsp_ch.any_in_use), int'(want.inuse));
			end
		end
	end

	// overall time limit
	initial begin
		#3_000_000;
		$display("[usage_counted_register_allocator] ERROR");
		$finish;
	end

	initial begin
		foreach (vec_use[r])
			vec_use[r] = ucra_pkg::CNT_ZERO;
		foreach (comp_use[r, c])
			comp_use[r][c] = ucra_pkg::CNT_ZERO;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = ucra_pkg::OP_CLEAR;
		req_ch.is_vector = 1'b0;
		req_ch.component_sel = '0;
		req_ch.reg_index = '0;
		req_ch.usage_amount = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_search_bound();
		test_random_phase(32, 1'b1, 0, 0, 110);
		test_random_phase(5, 1'b1, 46, 0, 160);
		test_random_phase(12, 1'b0, 0, 46, 160);
		test_random_phase(1, 1'b1, 31, 31, 160);
		test_result_backpressure();

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d items over %0d register settings, %0d results checked.",
			n_items, n_settings, n_checked);
		$display("Saw %0d overflows, %0d underflows and %0d busy queries; %0d mismatches.",
			n_overflow, n_underflow, n_busy_query, err_cnt);
		if (err_cnt == 0)
			$display("[usage_counted_register_allocator] OK");
		else
			$display("[usage_counted_register_allocator] ERROR");
		$finish;
	end

endmodule
